[hdl/first_occurrence_dedup_unit_macros.svh]
// Assertion helpers for the dedup unit.
`ifndef FIRST_OCCURRENCE_DEDUP_UNIT_MACROS_SVH
`define FIRST_OCCURRENCE_DEDUP_UNIT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define FODU_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fodu assertion failed");

// Next-cycle implication.
`define FODU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fodu assertion failed");

`else

`define FODU_ASSERT_NOW(label, clk, rst, ante, cons)
`define FODU_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[hdl/fodu_pkg.sv]
`default_nettype none

package fodu_pkg;

   localparam int DCOUNT_W = 7;

   typedef struct packed {
      logic signed [31:0] value;
      logic               last_item;
   } req_type;

   typedef struct packed {
      logic signed [31:0]    echoed_value;
      logic                  is_new;
      logic [DCOUNT_W-1:0]   distinct_count;
      logic                  overflow;
      logic                  run_end;
   } rsp_type;

   typedef enum logic [1:0] {
      SCAN_IDLE,
      SCAN_RUN,
      SCAN_DONE
   } scan_state_type;

endpackage

`default_nettype wire

[hdl/first_occurrence_dedup_unit.sv]
// Order-preserving dedup of runs of signed 32-bit values. Push one value per
// beat on the req_ side, with req_last_item set on the final value of a run;
// every request beat yields exactly one response beat, in order, carrying the
// value back, a first-occurrence flag, the running count of distinct values
// (low 7 bits), an overflow flag when a new value could not be stored because
// MAX_ITEMS distinct values are already held, and the run-end mark. After the
// run-end beat the store is empty again. Both sides are plain queues: a
// request beat goes in when req_push is high and req_full low, a response
// beat leaves when rsp_pop is high and rsp_empty low. The search engine
// reads the store of distinct values one entry per cycle from a single RAM
// read port, stopping at the first match or once every stored entry has
// been compared; with an empty store the search is skipped. A two-beat queue
// on each side lets the sender keep pushing and the receiver stall without
// holding up the search. No clearing pass is needed after reset.
`default_nettype none

module first_occurrence_dedup_unit
   import fodu_pkg::*;
#(
   parameter int MAX_ITEMS = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // request side
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire logic signed [31:0] req_value,
   input  wire logic               req_last_item,
   // response side
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output logic signed [31:0]      rsp_echoed_value,
   output logic                    rsp_is_new,
   output logic [DCOUNT_W-1:0]     rsp_distinct_count,
   output logic                    rsp_overflow,
   output logic                    rsp_run_end
);

   req_type req_item, front_item;
   rsp_type back_item, rsp_item;
   logic    front_empty, front_pop;
   logic    back_full, back_push;

   assign req_item.value     = req_value;
   assign req_item.last_item = req_last_item;

   // front: request queue, decouples the sender from the search engine
   fodu_queue #(
      .WIDTH ($bits(req_type)),
      .DEPTH (2)
   ) u_req_q (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .full    (req_full),
      .wr_data (req_item),
      .pop     (front_pop),
      .empty   (front_empty),
      .rd_data (front_item)
   );

   // back: walks the stored distinct values and updates the store
   fodu_scan #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .in_empty (front_empty),
      .in_item  (front_item),
      .in_pop   (front_pop),
      .out_full (back_full),
      .out_push (back_push),
      .out_item (back_item)
   );

   // response queue, lets the receiver stall while the next item searches
   fodu_queue #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (2)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .push    (back_push),
      .full    (back_full),
      .wr_data (back_item),
      .pop     (rsp_pop),
      .empty   (rsp_empty),
      .rd_data (rsp_item)
   );

   assign rsp_echoed_value   = rsp_item.echoed_value;
   assign rsp_is_new         = rsp_item.is_new;
   assign rsp_distinct_count = rsp_item.distinct_count;
   assign rsp_overflow       = rsp_item.overflow;
   assign rsp_run_end        = rsp_item.run_end;

endmodule

`default_nettype wire

[hdl/fodu_ram.sv]
`default_nettype none

module fodu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

[hdl/fodu_queue.sv]
`default_nettype none

module fodu_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int FW = $clog2(DEPTH + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             pop,
   output logic                  empty,
   output logic      [WIDTH-1:0] rd_data
);

   localparam logic [FW-1:0] FILL_MAX = FW'(DEPTH);
   localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [FW-1:0]    fill_ff, fill_in;
   logic             do_push, do_pop;

   assign full    = (fill_ff == FILL_MAX);
   assign empty   = (fill_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + FW'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - FW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

[hdl/fodu_scan.sv]
`default_nettype none
`include "first_occurrence_dedup_unit_macros.svh"

module fodu_scan
   import fodu_pkg::*;
#(
   parameter int MAX_ITEMS = 64,
   localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1,
   localparam int CW = $clog2(MAX_ITEMS + 1)
) (
   input  wire logic    clock,
   input  wire logic    reset,
   // from front queue
   input  wire logic    in_empty,
   input  wire req_type in_item,
   output logic         in_pop,
   // to result queue
   input  wire logic    out_full,
   output logic         out_push,
   output rsp_type      out_item
);

   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

   scan_state_type  state_ff, state_in;
   req_type         item_ff, item_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [CW-1:0]   issue_ff, issue_in;
   logic            pend_ff, pend_in;
   logic            found_ff, found_in;

   logic            rd_en;
   logic [31:0]     rd_data;
   logic            wr_en;
   logic            hit, last_cmp;
   logic            store_full, is_new;
   logic [CW-1:0]   new_count;
   logic [CW+DCOUNT_W-1:0] count_ext;

   assign hit        = pend_ff && (rd_data == item_ff.value);
   assign last_cmp   = pend_ff && (issue_ff == count_ff);
   assign store_full = (count_ff == MAX_CNT);
   assign is_new     = !found_ff && !store_full;
   assign new_count  = count_ff + CW'(is_new);
   assign count_ext  = {{DCOUNT_W{1'b0}}, new_count};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SCAN_IDLE: begin
            if (!in_empty) begin
               state_in = (count_ff == '0) ? SCAN_DONE : SCAN_RUN;
            end
         end
         SCAN_RUN: begin
            if (hit || last_cmp) begin
               state_in = SCAN_DONE;
            end
         end
         SCAN_DONE: begin
            if (!out_full) begin
               state_in = SCAN_IDLE;
            end
         end
         default: state_in = SCAN_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      in_pop   = 1'b0;
      rd_en    = 1'b0;
      out_push = 1'b0;
      wr_en    = 1'b0;
      item_in  = item_ff;
      issue_in = issue_ff;
      found_in = found_ff;
      count_in = count_ff;
      case (state_ff)
         SCAN_IDLE: begin
            in_pop = !in_empty;
            if (!in_empty) begin
               item_in  = in_item;
               issue_in = '0;
               found_in = 1'b0;
            end
         end
         SCAN_RUN: begin
            rd_en = (issue_ff != count_ff) && !hit;
            if (rd_en) begin
               issue_in = issue_ff + CW'(1);
            end
            if (hit) begin
               found_in = 1'b1;
            end
         end
         SCAN_DONE: begin
            if (!out_full) begin
               out_push = 1'b1;
               wr_en    = is_new;
               count_in = item_ff.last_item ? '0 : new_count;
            end
         end
         default: ;
      endcase
   end

   assign pend_in = rd_en;

   always_comb begin
      out_item.echoed_value   = item_ff.value;
      out_item.is_new         = is_new;
      out_item.distinct_count = count_ext[DCOUNT_W-1:0];
      out_item.overflow       = !found_ff && store_full;
      out_item.run_end        = item_ff.last_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SCAN_IDLE;
         count_ff <= '0;
         issue_ff <= '0;
         pend_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         issue_ff <= issue_in;
         pend_ff  <= pend_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   fodu_ram #(
      .WIDTH (32),
      .DEPTH (MAX_ITEMS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (item_ff.value),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   `FODU_ASSERT_NOW(a_count_bounded, clock, reset, 1'b1, count_ff <= MAX_CNT)
   `FODU_ASSERT_NOW(a_cmp_only_in_run, clock, reset, pend_ff, state_ff == SCAN_RUN)
   `FODU_ASSERT_NOW(a_new_xor_ovf, clock, reset, out_push,
                    !(out_item.is_new && out_item.overflow))
   `FODU_ASSERT_NEXT(a_run_end_clears, clock, reset,
                     out_push && item_ff.last_item, count_ff == '0)

endmodule

`default_nettype wire

[tb/sv/first_occurrence_dedup_checker.sv]
`timescale 1ns / 1ps

// Watches both queue ports of the dedup unit, keeps its own copy of the run
// store and checks every response beat against the oldest predicted one.
module first_occurrence_dedup_checker
   import fodu_pkg::*;
#(
   parameter int MAX_ITEMS = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   input  wire logic               req_full,
   input  wire logic signed [31:0] req_value,
   input  wire logic               req_last_item,
   input  wire logic               rsp_empty,
   input  wire logic               rsp_pop,
   input  wire logic signed [31:0] rsp_echoed_value,
   input  wire logic               rsp_is_new,
   input  wire logic [DCOUNT_W-1:0] rsp_distinct_count,
   input  wire logic               rsp_overflow,
   input  wire logic               rsp_run_end,
   output int                      mismatch_count,
   output int                      awaited_count
);

   logic signed [31:0] run_values [MAX_ITEMS];
   int                 held_count;
   rsp_type            awaited_beats [$];

   initial begin
      mismatch_count = 0;
      awaited_count  = 0;
      held_count     = 0;
   end

   // Look the value up among the distinct values of the current run.
   function automatic rsp_type classify_value(input logic signed [31:0] v, input logic last);
      rsp_type r;
      bit      found;
      found = 1'b0;
      for (int i = 0; i < held_count; i++) begin
         if (run_values[i] == v) found = 1'b1;
      end
      r.echoed_value = v;
      r.is_new       = 1'b0;
      r.overflow     = 1'b0;
      r.run_end      = last;
      if (!found) begin
         if (held_count < MAX_ITEMS) begin
            run_values[held_count] = v;
            held_count++;
            r.is_new = 1'b1;
         end else begin
            r.overflow = 1'b1;
         end
      end
      r.distinct_count = DCOUNT_W'(held_count);
      if (last) held_count = 0;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         held_count = 0;
         awaited_beats.delete();
      end else begin
         if (req_push && !req_full)
            awaited_beats.push_back(classify_value(req_value, req_last_item));
         if (rsp_pop && !rsp_empty) begin
            if (awaited_beats.size() == 0) begin
               $display("%0t: unexpected response beat, expected none, actual value 0x%0h",
                        $time, rsp_echoed_value);
               mismatch_count++;
            end else begin
               want = awaited_beats.pop_front();
               check_field("echoed_value", want.echoed_value, rsp_echoed_value);
               check_field("is_new", 32'(want.is_new), 32'(rsp_is_new));
               check_field("distinct_count", 32'(want.distinct_count),
                           32'(rsp_distinct_count));
               check_field("overflow", 32'(want.overflow), 32'(rsp_overflow));
               check_field("run_end", 32'(want.run_end), 32'(rsp_run_end));
            end
         end
      end
      awaited_count = awaited_beats.size();
   end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

// Top of the dedup unit bench: clock, reset, request stimulus and response
// back-pressure and a watchdog. All other checking lives in the checker;
// this module collects its mismatch and awaited counts and prints the verdict.
module testbench;
   import fodu_pkg::*;

   localparam int MAX_ITEMS   = 64;
   // Watchdog limit for the whole run, set with heavy idling in mind.
   localparam int CYCLE_LIMIT = 600_000;
   localparam logic signed [31:0] MOST_NEG = 32'sh8000_0000;
   localparam logic signed [31:0] MOST_POS = 32'sh7FFF_FFFF;

   logic                    clock         = 1'b0;
   logic                    reset         = 1'b1;
   logic                    req_push      = 1'b0;
   logic                    req_full;
   logic signed [31:0]      req_value     = '0;
   logic                    req_last_item = 1'b0;
   logic                    rsp_empty;
   logic                    rsp_pop       = 1'b0;
   logic signed [31:0]      rsp_echoed_value;
   logic                    rsp_is_new;
   logic [DCOUNT_W-1:0]     rsp_distinct_count;
   logic                    rsp_overflow;
   logic                    rsp_run_end;

   int mismatch_count;
   int awaited_count;
   int cycle_count   = 0;
   int beats_sent    = 0;
   // Idle odds in percent, changed per phase.
   int send_idle_pct = 0;
   int pop_stall_pct = 0;

   always #2 clock = ~clock;

   first_occurrence_dedup_unit #(.MAX_ITEMS(MAX_ITEMS)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_value          (req_value),
      .req_last_item      (req_last_item),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_echoed_value   (rsp_echoed_value),
      .rsp_is_new         (rsp_is_new),
      .rsp_distinct_count (rsp_distinct_count),
      .rsp_overflow       (rsp_overflow),
      .rsp_run_end        (rsp_run_end)
   );

   first_occurrence_dedup_checker #(.MAX_ITEMS(MAX_ITEMS)) dedup_check (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_value          (req_value),
      .req_last_item      (req_last_item),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_echoed_value   (rsp_echoed_value),
      .rsp_is_new         (rsp_is_new),
      .rsp_distinct_count (rsp_distinct_count),
      .rsp_overflow       (rsp_overflow),
      .rsp_run_end        (rsp_run_end),
      .mismatch_count     (mismatch_count),
      .awaited_count      (awaited_count)
   );

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("[first_occurrence_dedup_unit] ERROR");
         $finish;
      end
   end

   // Receiver: one pop decision per cycle, made at the falling edge so the
   // block sees a stable rsp_pop at the next rising edge.
   always @(negedge clock) begin
      rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
   end

   // Mostly full-range random values, with the corners mixed in so repeats
   // of the extremes show up inside runs too.
   function automatic logic signed [31:0] draw_value();
      case ($urandom_range(19))
         0:       return MOST_NEG;
         1:       return MOST_POS;
         2:       return 32'sd0;
         3:       return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   // One request beat. Called at a falling edge, returns at a falling edge;
   // req_push gets at most one update per falling edge, so a back-to-back
   // beat never drops push for a step.
   task automatic send_beat(input logic signed [31:0] v, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push      <= 1'b1;
      req_value     <= v;
      req_last_item <= last;
      @(posedge clock);
      while (req_full) @(posedge clock);
      beats_sent++;
      @(negedge clock);
   endtask

   // A run of n values drawn from a pool of pool_size random values. With
   // in_order set the pool is walked front to back first, so every entry shows
   // up when n >= pool_size; over MAX_ITEMS distinct ones overflow the store.
   task automatic send_run(input int n, input int pool_size, input bit in_order);
      logic signed [31:0] pool [$];
      logic signed [31:0] v;
      for (int k = 0; k < pool_size; k++) pool.push_back(draw_value());
      for (int i = 0; i < n; i++) begin
         if (in_order && i < pool_size) v = pool[i];
         else v = pool[$urandom_range(pool_size - 1)];
         send_beat(v, i == n - 1);
      end
   endtask

   // Random phase: opens with a run that can overflow the store (and repeats
   // pool values), then a mix of short, medium and near-full runs.
   task automatic run_phase(input int sender_pct, input int receiver_pct, input int beats);
      int stop_at;
      int pool_size;
      send_idle_pct = sender_pct;
      pop_stall_pct = receiver_pct;
      stop_at       = beats_sent + beats;
      pool_size     = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 16);
      send_run(pool_size + $urandom_range(5, 15), pool_size, 1'b1);
      while (beats_sent < stop_at) begin
         case ($urandom_range(9))
            0, 1, 2:       send_run($urandom_range(1, 6), $urandom_range(1, 4), 1'b0);
            3, 4, 5, 6, 7: send_run($urandom_range(5, 30), $urandom_range(1, 20), 1'b0);
            8:             send_run($urandom_range(30, MAX_ITEMS), $urandom_range(20, MAX_ITEMS),
                                    1'(($urandom_range(1))));
            default:       send_run(1, 1, 1'b0);
         endcase
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed beats, no idling.
      // Single-item runs at both extremes: stored, new, count 1, run ends.
      send_beat(MOST_NEG, 1'b1);
      send_beat(MOST_POS, 1'b1);
      // Mixed run: repeats, alternating bit patterns, extremes, and a last
      // beat that is a repeat rather than a new value.
      send_beat(32'sd0, 1'b0);
      send_beat(-32'sd1, 1'b0);
      send_beat(32'sd0, 1'b0);
      send_beat(32'sh5555_5555, 1'b0);
      send_beat(32'shAAAA_AAAA, 1'b0);
      send_beat(MOST_NEG, 1'b0);
      send_beat(MOST_POS, 1'b0);
      send_beat(MOST_POS, 1'b0);
      send_beat(32'sd1, 1'b0);
      send_beat(-32'sd1, 1'b1);
      // Store must be empty again: same value twice, both sides of a run end.
      send_beat(32'sd7, 1'b0);
      send_beat(32'sd7, 1'b1);
      send_beat(32'sd7, 1'b1);
      send_beat(32'sd0, 1'b1);

      // Random phases: free-running, slow sender, slow receiver, both jittery.
      run_phase(0, 0, 200);
      run_phase(77, 0, 200);
      run_phase(0, 77, 200);
      run_phase(13, 13, 200);

      req_push      <= 1'b0;
      pop_stall_pct  = 0;
      while (awaited_count != 0) @(negedge clock);
      // Drain time for a stray beat still in the search pipe.
      repeat (MAX_ITEMS + 8) @(negedge clock);

      if (mismatch_count == 0 && awaited_count == 0) begin
         $display("[first_occurrence_dedup_unit] OK");
      end else begin
         $display("[first_occurrence_dedup_unit] ERROR");
      end
      $finish;
   end

endmodule
